/* rtl/ctsr_pkg.sv */
// ----------------------------------------------------------------------------
// ctsr_pkg
// shared types and constants of the transport session receiver
// ----------------------------------------------------------------------------
package ctsr_pkg;

    // storage sizing
    localparam int unsigned MAX_PACKETS  = 255;
    localparam int unsigned PACKET_BYTES = 7;
    localparam int unsigned NUM_PEERS    = 256;
    localparam int unsigned PAYLOAD_DEPTH = NUM_PEERS * MAX_PACKETS;
    localparam int unsigned PAYLOAD_AW    = $clog2(PAYLOAD_DEPTH);
    localparam int unsigned PAYLOAD_W     = PACKET_BYTES * 8;

    // queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration port
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_OWN_ADDRESS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLY_ADDRESS = 2'd1;

    // protocol codes
    localparam logic [7:0]  PF_CONTROL    = 8'hEC;
    localparam logic [7:0]  PF_DATA       = 8'hEB;
    localparam logic [7:0]  CTL_REQUEST   = 8'd16;
    localparam logic [7:0]  CTL_ABORT     = 8'd255;
    localparam logic [7:0]  CTL_GRANT     = 8'd17;
    localparam logic [7:0]  GRANT_NEXT    = 8'd1;
    localparam logic [7:0]  GRANT_RSVD    = 8'hFF;
    localparam logic [28:0] GRANT_ID_BASE = 29'h18EC0000;

    // event codes
    localparam logic [2:0] EV_IGNORED  = 3'd0;
    localparam logic [2:0] EV_GRANT    = 3'd1;
    localparam logic [2:0] EV_STORED   = 3'd2;
    localparam logic [2:0] EV_COMPLETE = 3'd3;
    localparam logic [2:0] EV_BAD_SEQ  = 3'd4;
    localparam logic [2:0] EV_ABORTED  = 3'd5;
    localparam logic [2:0] EV_ZERO_SEQ = 3'd6;

    // frame class decided by the front
    typedef enum logic [1:0] {
        KIND_IGNORE,
        KIND_REQUEST,
        KIND_ABORT,
        KIND_DATA
    } kind_t;

    // one queued frame, data[0] is byte1
    typedef struct packed {
        kind_t                        kind;
        logic [7:0]                   src;
        logic [7:0]                   seq;
        logic [PACKET_BYTES-1:0][7:0] data;
    } entry_t;

    // per peer session bookkeeping
    typedef struct packed {
        logic [7:0] expected;
        logic [7:0] count;
    } sess_t;

    // one result word
    typedef struct packed {
        logic [2:0]      event_res;
        logic [7:0]      peer_address;
        logic [28:0]     reply_frame_id;
        logic [7:0][7:0] reply_bytes;
    } result_t;

    typedef enum logic {
        BK_IDLE,
        BK_EXEC
    } back_state_t;

endpackage

/* rtl/ctsr_front.sv */
// ----------------------------------------------------------------------------
// ctsr_front
// address filter and frame classifier ahead of the queue
// ----------------------------------------------------------------------------
module ctsr_front (
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [28:0]      s_frame_id,
    input  logic [7:0]       s_byte0,
    input  logic [7:0]       s_byte1,
    input  logic [7:0]       s_byte2,
    input  logic [7:0]       s_byte3,
    input  logic [7:0]       s_byte4,
    input  logic [7:0]       s_byte5,
    input  logic [7:0]       s_byte6,
    input  logic [7:0]       s_byte7,
    input  logic [7:0]       own_address,
    output logic             push,
    output ctsr_pkg::entry_t push_entry,
    input  logic             queue_full
);
    import ctsr_pkg::*;

    logic [7:0] pf;
    logic [7:0] dst;

    assign pf      = s_frame_id[23:16];
    assign dst     = s_frame_id[15:8];
    assign s_ready = !queue_full;
    assign push    = s_valid && !queue_full;

    always_comb begin
        push_entry.src  = s_frame_id[7:0];
        push_entry.seq  = s_byte0;
        push_entry.data = {s_byte7, s_byte6, s_byte5, s_byte4, s_byte3, s_byte2, s_byte1};
        push_entry.kind = KIND_IGNORE;
        if (dst == own_address) begin
            if (pf == PF_CONTROL && s_byte0 == CTL_REQUEST) begin
                push_entry.kind = KIND_REQUEST;
            end else if (pf == PF_CONTROL && s_byte0 == CTL_ABORT) begin
                push_entry.kind = KIND_ABORT;
            end else if (pf == PF_DATA) begin
                push_entry.kind = KIND_DATA;
            end
        end
    end

endmodule

/* rtl/ctsr_fifo.sv */
// ----------------------------------------------------------------------------
// ctsr_fifo
// short queue of classified frames between front and back
// ----------------------------------------------------------------------------
module ctsr_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  ctsr_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output ctsr_pkg::entry_t pop_entry
);
    import ctsr_pkg::*;

    entry_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* rtl/ctsr_back.sv */
// ----------------------------------------------------------------------------
// ctsr_back
// session update engine: reads a peer's session, updates it, stores payload
// ----------------------------------------------------------------------------
module ctsr_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              queue_not_empty,
    input  ctsr_pkg::entry_t  queue_entry,
    output logic              pop,
    input  logic [7:0]        reply_source_address,
    output logic              m_valid,
    input  logic              m_ready,
    output ctsr_pkg::result_t result
);
    import ctsr_pkg::*;

    back_state_t           state_reg, state_next;
    entry_t                entry_reg;
    sess_t                 sess_q_reg;
    logic [NUM_PEERS-1:0]  open_reg;
    logic                  m_valid_reg, m_valid_next;
    result_t               result_reg, result_next;

    sess_t                 sess_mem [NUM_PEERS];
    logic [PAYLOAD_W-1:0]  payload_mem [PAYLOAD_DEPTH];

    logic                  open_bit;
    logic                  open_set, open_clr;
    logic                  sess_we;
    sess_t                 sess_wdata;
    logic                  pay_we;
    logic [PAYLOAD_AW-1:0] pay_addr;
    logic [7:0]            count_inc;
    logic                  res_load;

    assign open_bit  = open_reg[entry_reg.src];
    assign count_inc = sess_q_reg.count + 8'd1;
    // slot of packet seq (from 1) in this peer's region
    assign pay_addr  = PAYLOAD_AW'(entry_reg.src) * PAYLOAD_AW'(MAX_PACKETS)
                     + PAYLOAD_AW'(entry_reg.seq) - PAYLOAD_AW'(1);

    assign m_valid = m_valid_reg;
    assign result  = result_reg;

    always_comb begin
        state_next  = state_reg;
        pop         = 1'b0;
        open_set    = 1'b0;
        open_clr    = 1'b0;
        sess_we     = 1'b0;
        sess_wdata  = sess_q_reg;
        pay_we      = 1'b0;
        res_load    = 1'b0;
        result_next = '0;
        result_next.peer_address = entry_reg.src;

        unique case (state_reg)
            BK_IDLE: begin
                if (queue_not_empty) begin
                    pop        = 1'b1;
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC: begin
                if (!m_valid_reg || m_ready) begin
                    res_load   = 1'b1;
                    state_next = BK_IDLE;
                    unique case (entry_reg.kind)
                        KIND_REQUEST: begin
                            open_set            = 1'b1;
                            sess_we             = 1'b1;
                            sess_wdata.expected = entry_reg.data[2];
                            sess_wdata.count    = open_bit ? sess_q_reg.count : 8'd0;
                            result_next.event_res      = EV_GRANT;
                            result_next.reply_frame_id = GRANT_ID_BASE
                                | {13'd0, entry_reg.src, reply_source_address};
                            result_next.reply_bytes = {entry_reg.data[6], entry_reg.data[5],
                                                       entry_reg.data[4], GRANT_RSVD,
                                                       GRANT_RSVD, GRANT_NEXT,
                                                       entry_reg.data[3], CTL_GRANT};
                        end
                        KIND_ABORT: begin
                            if (open_bit) begin
                                open_clr              = 1'b1;
                                result_next.event_res = EV_ABORTED;
                            end
                        end
                        KIND_DATA: begin
                            if (open_bit) begin
                                sess_we          = 1'b1;
                                sess_wdata.count = count_inc;
                                if (entry_reg.seq == 8'd0) begin
                                    result_next.event_res = EV_ZERO_SEQ;
                                end else if (entry_reg.seq > sess_q_reg.expected) begin
                                    open_clr              = 1'b1;
                                    result_next.event_res = EV_BAD_SEQ;
                                end else begin
                                    pay_we = ({1'b0, entry_reg.seq} <= 9'(MAX_PACKETS));
                                    if (count_inc >= sess_q_reg.expected) begin
                                        open_clr              = 1'b1;
                                        result_next.event_res = EV_COMPLETE;
                                    end else begin
                                        result_next.event_res = EV_STORED;
                                    end
                                end
                            end
                        end
                        default: begin
                            result_next.event_res = EV_IGNORED;
                        end
                    endcase
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase

        if (res_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            open_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (open_set) begin
                open_reg[entry_reg.src] <= 1'b1;
            end else if (open_clr) begin
                open_reg[entry_reg.src] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            entry_reg <= queue_entry;
        end
        if (res_load) begin
            result_reg <= result_next;
        end
    end

    // session memory, registered read issued at pop
    always_ff @(posedge aclk) begin
        if (pop) begin
            sess_q_reg <= sess_mem[queue_entry.src];
        end
        if (sess_we) begin
            sess_mem[entry_reg.src] <= sess_wdata;
        end
    end

    // payload store, write only
    always_ff @(posedge aclk) begin
        if (pay_we) begin
            payload_mem[pay_addr] <= entry_reg.data;
        end
    end

endmodule

/* rtl/can_transport_session_receiver.sv */
// ----------------------------------------------------------------------------
// can_transport_session_receiver
// receive side of the rts/cts transport session protocol on 29-bit can frames
// ----------------------------------------------------------------------------
// Takes one received frame per s_ word and returns exactly one m_ word for it,
// in order. The front filters on own_address and sorts the frame into request,
// abort, data or ignored, and pushes it into a two-entry queue, so s_ready
// only drops while that queue is full. The back engine handles one frame at a
// time: its idle state pops the queue and issues a registered read of the
// peer's session entry (expected packet count and received count) from a
// 256-entry memory, and its execute state updates that entry, the open flag
// and the payload store and loads the result register; the execute state
// waits while an earlier result is held with m_ready low. Session open flags
// are flip-flops cleared by reset, so no clearing pass is needed. The payload
// store (256 peers x 255 packets x 7 bytes) starts undefined and is never
// read; the session memory starts undefined too, and an entry is only used
// once written. Reply fields are zero unless the event is a grant.
// Configuration writes (index 0 own address, 1 reply source address) are
// always accepted and should only be issued while the block is idle.
// ----------------------------------------------------------------------------
module can_transport_session_receiver (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ctsr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [7:0]                           cfg_data,
    // received frame
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [28:0]                          s_frame_id,
    input  logic [7:0]                           s_byte0,
    input  logic [7:0]                           s_byte1,
    input  logic [7:0]                           s_byte2,
    input  logic [7:0]                           s_byte3,
    input  logic [7:0]                           s_byte4,
    input  logic [7:0]                           s_byte5,
    input  logic [7:0]                           s_byte6,
    input  logic [7:0]                           s_byte7,
    // result
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [2:0]                           m_event_res,
    output logic [7:0]                           m_peer_address,
    output logic [28:0]                          m_reply_frame_id,
    output logic [7:0]                           m_reply_byte0,
    output logic [7:0]                           m_reply_byte1,
    output logic [7:0]                           m_reply_byte2,
    output logic [7:0]                           m_reply_byte3,
    output logic [7:0]                           m_reply_byte4,
    output logic [7:0]                           m_reply_byte5,
    output logic [7:0]                           m_reply_byte6,
    output logic [7:0]                           m_reply_byte7
);
    import ctsr_pkg::*;

    // configuration registers
    logic [7:0] own_address_reg;
    logic [7:0] reply_address_reg;

    // front to queue
    logic       push;
    entry_t     push_entry;
    logic       queue_full;

    // queue to back
    logic       pop;
    logic       queue_not_empty;
    entry_t     queue_entry;

    result_t    result;

    // register writes never stall
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_address_reg   <= 8'd0;
            reply_address_reg <= 8'd0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_OWN_ADDRESS:   own_address_reg   <= cfg_data;
                CFG_REPLY_ADDRESS: reply_address_reg <= cfg_data;
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    // address filter and classifier
    ctsr_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_frame_id  (s_frame_id),
        .s_byte0     (s_byte0),
        .s_byte1     (s_byte1),
        .s_byte2     (s_byte2),
        .s_byte3     (s_byte3),
        .s_byte4     (s_byte4),
        .s_byte5     (s_byte5),
        .s_byte6     (s_byte6),
        .s_byte7     (s_byte7),
        .own_address (own_address_reg),
        .push        (push),
        .push_entry  (push_entry),
        .queue_full  (queue_full)
    );

    // decoupling queue
    ctsr_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .not_empty  (queue_not_empty),
        .pop_entry  (queue_entry)
    );

    // session engine with result register
    ctsr_back u_back (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .queue_not_empty      (queue_not_empty),
        .queue_entry          (queue_entry),
        .pop                  (pop),
        .reply_source_address (reply_address_reg),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .result               (result)
    );

    // result word onto the output ports
    assign m_event_res      = result.event_res;
    assign m_peer_address   = result.peer_address;
    assign m_reply_frame_id = result.reply_frame_id;
    assign m_reply_byte0    = result.reply_bytes[0];
    assign m_reply_byte1    = result.reply_bytes[1];
    assign m_reply_byte2    = result.reply_bytes[2];
    assign m_reply_byte3    = result.reply_bytes[3];
    assign m_reply_byte4    = result.reply_bytes[4];
    assign m_reply_byte5    = result.reply_bytes[5];
    assign m_reply_byte6    = result.reply_bytes[6];
    assign m_reply_byte7    = result.reply_bytes[7];

endmodule
